[rtl/sbfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfr_pkg: shared types and constants for the start-byte frame receiver
// Frame length, field widths and the per-word result record.
// ----------------------------------------------------------------------------
package sbfr_pkg;

  // Bytes following the start byte: payload plus one checksum byte.
  localparam int unsigned FrameBytes = 64;
  localparam int unsigned PosW       = 7;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 32;

  localparam logic [PosW-1:0] LastPos = PosW'(FrameBytes);

  typedef struct packed {
    logic              captured;
    logic [PosW-1:0]   position;
    logic [ByteW-1:0]  data_byte;
    logic              frame_done;
    logic              frame_good;
    logic [CountW-1:0] good_frames;
    logic [CountW-1:0] bad_frames;
  } sbfr_result_t;

endpackage

[rtl/sbfr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfr_core: frame tracking, running checksum and frame counters
// Builds the result for the current word and updates state on accept.
// ----------------------------------------------------------------------------
module sbfr_core import sbfr_pkg::*; #(
  parameter int unsigned FrameLen = FrameBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [ByteW-1:0]   sof_byte_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  output sbfr_result_t       result_o
);

  // position of the checksum byte
  localparam logic [PosW-1:0] FrameEnd = PosW'(FrameLen);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [CountW-1:0] good_q, good_d;
  logic [CountW-1:0] bad_q, bad_d;

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    good_d = good_q;
    bad_d  = bad_q;
    result_o = '0;
    if (pos_q == '0) begin
      // idle: only the start byte opens a frame
      if (rx_byte_i == sof_byte_i) begin
        result_o.captured  = 1'b1;
        result_o.data_byte = rx_byte_i;
        sum_d = '0;
        pos_d = PosW'(1);
      end
    end else begin
      result_o.captured  = 1'b1;
      result_o.position  = pos_q;
      result_o.data_byte = rx_byte_i;
      if (pos_q < FrameEnd) begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + PosW'(1);
      end else begin
        // checksum byte closes the frame
        result_o.frame_done = 1'b1;
        if (sum_q == rx_byte_i) begin
          result_o.frame_good = 1'b1;
          good_d = good_q + CountW'(1);
        end else begin
          bad_d = bad_q + CountW'(1);
        end
        pos_d = '0;
        sum_d = '0;
      end
    end
    result_o.good_frames = good_d;
    result_o.bad_frames  = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      good_q <= '0;
      bad_q  <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      good_q <= good_d;
      bad_q  <= bad_d;
    end
  end

endmodule

[rtl/start_byte_frame_receiver_checksum_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_byte_frame_receiver_checksum_unit: serial deframer with 8-bit sum check
// Result words are registered in the output register, or in the skid stage
// while it is stalled. Throughput: one byte word per cycle unless the skid stage
// holds a word; output register plus skid stage keep input accepts going for one extra word on a stall.
// Reset (rst_ni, async, active low): idle, sum and both frame counters zero,
// start byte register zero, no result words held.
// ----------------------------------------------------------------------------
module start_byte_frame_receiver_checksum_unit import sbfr_pkg::*; #(
  parameter int unsigned FrameLen = FrameBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: start byte register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ByteW-1:0]  cfg_sof_byte_i,
  // received byte words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              captured_o,
  output logic [PosW-1:0]   position_o,
  output logic [ByteW-1:0]  data_byte_o,
  output logic              frame_done_o,
  output logic              frame_good_o,
  output logic [CountW-1:0] good_frames_o,
  output logic [CountW-1:0] bad_frames_o
);

  logic [ByteW-1:0] sof_byte_q;
  logic             in_acc;
  logic             out_take;
  sbfr_result_t     res;
  sbfr_result_t     out_q, out_d;
  sbfr_result_t     skid_q, skid_d;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;

  // Config register is always writable; the user must write it only while idle, the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_byte_q <= '0;
    end else if (cfg_valid_i) begin
      sof_byte_q <= cfg_sof_byte_i;
    end
  end

  // Input is held off only while the skid stage holds a word.
  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  // Frame tracker: result is combinational from state and the byte,
  // state advances on accept.
  sbfr_core #(
    .FrameLen(FrameLen)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .sof_byte_i(sof_byte_q),
    .rx_byte_i (rx_byte_i),
    .result_o  (res)
  );

  // Output register with skid stage behind it.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_acc) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      // output stalled: park the new word
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign captured_o    = out_q.captured;
  assign position_o    = out_q.position;
  assign data_byte_o   = out_q.data_byte;
  assign frame_done_o  = out_q.frame_done;
  assign frame_good_o  = out_q.frame_good;
  assign good_frames_o = out_q.good_frames;
  assign bad_frames_o  = out_q.bad_frames;

  // Skid stage only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  // A good flag only comes on a frame-closing word.
  a_good_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_good |-> out_q.frame_done)
    else $error("frame_good without frame_done");

  // Uncaptured bytes carry no position and never close a frame.
  a_uncaptured_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.captured |-> out_q.position == '0 && !out_q.frame_done)
    else $error("uncaptured word carries frame information");

  // An accept into an empty pipe shows up on the output next cycle.
  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_q |=> out_valid_q)
    else $error("accepted word did not reach the output register");

endmodule

[tb/start_byte_frame_receiver_checksum_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_byte_frame_receiver_checksum_unit_tb: self-checking bench for the deframer
// Streams byte words (noise, whole frames with good and bad sums, cut-short
// frames) under several start byte settings. A predictor tracks
// frame position, running sum and both frame counters. Every result word is
// compared against it in order. Both sides stall at random. One long
// output hold backs the block up.
// ----------------------------------------------------------------------------
module start_byte_frame_receiver_checksum_unit_tb;
  import sbfr_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int PhaseWords = 360;
  localparam int HoldCycles = 60;

  // Predicts the result word for every accepted byte word and checks the
  // words coming out against those predictions, oldest first.
  class deframe_scoreboard;
    logic [ByteW-1:0]  sof_byte;
    logic [PosW-1:0]   frame_pos;
    logic [ByteW-1:0]  chk_sum;
    logic [CountW-1:0] good_cnt;
    logic [CountW-1:0] bad_cnt;
    sbfr_result_t      pending_results[$];
    int                errors;

    function new();
      sof_byte  = '0;
      frame_pos = '0;
      chk_sum   = '0;
      good_cnt  = '0;
      bad_cnt   = '0;
      errors    = 0;
    endfunction

    function void set_sof_byte(logic [ByteW-1:0] v);
      sof_byte = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_rx_byte(logic [ByteW-1:0] b);
      sbfr_result_t r;
      r = '0;
      if (frame_pos == '0) begin
        // idle: only the start byte opens a frame
        if (b == sof_byte) begin
          r.captured  = 1'b1;
          r.data_byte = b;
          chk_sum     = '0;
          frame_pos   = PosW'(1);
        end
      end else begin
        r.captured  = 1'b1;
        r.position  = frame_pos;
        r.data_byte = b;
        if (frame_pos < LastPos) begin
          chk_sum   = chk_sum + b;
          frame_pos = frame_pos + 1'b1;
        end else begin
          // last byte carries the checksum
          r.frame_done = 1'b1;
          if (chk_sum == b) begin
            r.frame_good = 1'b1;
            good_cnt     = good_cnt + 1'b1;
          end else begin
            bad_cnt = bad_cnt + 1'b1;
          end
          frame_pos = '0;
          chk_sum   = '0;
        end
      end
      r.good_frames = good_cnt;
      r.bad_frames  = bad_cnt;
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(sbfr_result_t got);
      sbfr_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      cmp_field("captured",    exp_r.captured,    got.captured);
      cmp_field("position",    exp_r.position,    got.position);
      cmp_field("data_byte",   exp_r.data_byte,   got.data_byte);
      cmp_field("frame_done",  exp_r.frame_done,  got.frame_done);
      cmp_field("frame_good",  exp_r.frame_good,  got.frame_good);
      cmp_field("good_frames", exp_r.good_frames, got.good_frames);
      cmp_field("bad_frames",  exp_r.bad_frames,  got.bad_frames);
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [ByteW-1:0]  cfg_sof_byte_i = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  rx_byte_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              captured_o;
  logic [PosW-1:0]   position_o;
  logic [ByteW-1:0]  data_byte_o;
  logic              frame_done_o;
  logic              frame_good_o;
  logic [CountW-1:0] good_frames_o;
  logic [CountW-1:0] bad_frames_o;

  deframe_scoreboard sb = new();

  // pacing knobs shared by the sender and the receiver
  bit               tx_gaps   = 1'b0;
  bit               rx_gaps   = 1'b0;
  bit               quiet     = 1'b0;  // last phase: no idling at all
  bit               hold_req  = 1'b0;  // asks the receiver for one long hold
  int               stall_left = 0;
  int               cycle_cnt  = 0;
  int               phase_words;
  logic [ByteW-1:0] cur_start = '0;

  start_byte_frame_receiver_checksum_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_sof_byte_i (cfg_sof_byte_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .captured_o     (captured_o),
    .position_o     (position_o),
    .data_byte_o    (data_byte_o),
    .frame_done_o   (frame_done_o),
    .frame_good_o   (frame_good_o),
    .good_frames_o  (good_frames_o),
    .bad_frames_o   (bad_frames_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("start_byte_frame_receiver_checksum_unit: mismatch");
      $finish;
    end
  end

  // Receiver: checks accepted result words and decides out_ready for the
  // next edge. Values read here are the ones the block saw at this edge.
  always @(posedge clk_i) begin
    sbfr_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {captured_o, position_o, data_byte_o, frame_done_o, frame_good_o,
             good_frames_o, bad_frames_o};
      sb.check_result(got);
    end
    // occasionally flip between gappy and clean stretches
    if ($urandom_range(0, 99) == 0) rx_gaps = !rx_gaps;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      // long hold: output reg and skid stage fill, input must stall
      hold_req   = 1'b0;
      stall_left = HoldCycles - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && rx_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offer one byte word and wait for it to be taken. Called right after a
  // rising edge; returns at the accepting edge.
  task automatic send_byte(input logic [ByteW-1:0] b);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_rx_byte(b);
    phase_words++;
  endtask

  task automatic idle_in(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sender side idling: random idle bursts, only in gappy stretches.
  task automatic paced_send(input logic [ByteW-1:0] b);
    if ($urandom_range(0, 79) == 0) tx_gaps = !tx_gaps;
    if (!quiet && tx_gaps && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 9));
    send_byte(b);
  endtask

  // Stop offering and wait for every predicted result word.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_sof_byte(input logic [ByteW-1:0] v);
    drain_results();
    cfg_valid_i    <= 1'b1;
    cfg_sof_byte_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_sof_byte(v);
    cur_start = v;
  endtask

  function automatic logic [ByteW-1:0] noise_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255)); while (b == cur_start);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] payload_byte();
    case ($urandom_range(0, 15))
      0:       return cur_start;  // start byte value inside a frame
      1:       return '0;
      2:       return '1;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // Start byte, FrameBytes-1 payload bytes, then the checksum byte.
  task automatic send_frame(input bit sum_ok);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    sum = '0;
    paced_send(cur_start);
    for (int k = 1; k < FrameBytes; k++) begin
      b = payload_byte();
      sum = sum + b;
      paced_send(b);
    end
    if (sum_ok) paced_send(sum);
    else        paced_send(sum ^ ByteW'($urandom_range(1, 255)));
  endtask

  // Random traffic for one phase: mostly whole frames, some noise and
  // frames that may be cut short (the next bytes get swallowed into them).
  task automatic random_phase(input int phase);
    int fr;
    int n;
    fr = 0;
    phase_words = 0;
    while (phase_words < PhaseWords) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n) paced_send(noise_byte());
        end
        2: begin
          paced_send(cur_start);
          n = $urandom_range(1, 70);
          repeat (n) paced_send(payload_byte());
        end
        default: begin
          // first frames of the run: one good, one bad for sure
          if (phase == 0 && fr < 2) send_frame(fr == 0);
          else                      send_frame($urandom_range(0, 2) != 0);
          fr++;
        end
      endcase
      if (phase == 1 && fr == 2) begin
        // sender waits for the block to empty out completely
        drain_results();
        fr++;
      end
      if (phase == 2 && fr == 1) begin
        // back-to-back words into a long output hold
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        fr++;
      end
    end
  endtask

  initial begin
    logic [ByteW-1:0] settings [5];
    logic [ByteW-1:0] directed [8];
    settings = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'h00};
    settings[2] = ByteW'($urandom_range(1, 254));
    directed = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h02};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle bytes that do not match the reset start byte,
    // including both extremes, then the random phases.
    foreach (directed[i]) send_byte(directed[i]);

    for (int ph = 0; ph < 5; ph++) begin
      // phase 0 runs on the reset value; the last one rewrites zero
      if (ph > 0) write_sof_byte(settings[ph]);
      if (ph == 4) quiet = 1'b1;
      random_phase(ph);
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("start_byte_frame_receiver_checksum_unit: match");
    end else begin
      $display("start_byte_frame_receiver_checksum_unit: mismatch");
    end
    $finish;
  end

endmodule
